FILE: rtl/floyd_sample_without_replacement_assert.svh
`ifndef FLOYD_SAMPLE_WITHOUT_REPLACEMENT_ASSERT_SVH
`define FLOYD_SAMPLE_WITHOUT_REPLACEMENT_ASSERT_SVH

// same-cycle implication
`define FSWR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FSWR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/fswr_pkg.sv
package fswr_pkg;

   localparam int DRAW_W  = 32;
   localparam int SLOT_W  = 6;
   localparam int COUNT_W = 7;
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 32;

   localparam logic [DRAW_W-1:0]  POP_RESET   = 32'd64;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd1;

   typedef enum logic [1:0] {
      REG_POPULATION = 2'd0,
      REG_SAMPLE_CNT = 2'd1,
      REG_ORDER_MODE = 2'd2
   } csr_index_type;

endpackage

FILE: rtl/fswr_ram.sv
module fswr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/floyd_sample_without_replacement.sv
// channel   direction  handshake                  payload
// req       in         req_valid / req_stall      req_draw
// rsp       out        rsp_valid / rsp_stall      rsp_slot, rsp_picked_value, rsp_last_of_run,
//                                                 rsp_sample_done, rsp_draw_error
// csr       in         csr_psel/penable/pready    csr_paddr, csr_pwdata, csr_prdata
//
// a request passes through sum, subtract and range check, then searches the earlier picks
// (skipped at step 0, ended early when the draw matches one) through the single read port
// of the store; a second write follows on a match in ordered mode.
// a rejected draw skips the search and the write. one request is in flight at a time.
// reset clears the step index and loads register defaults; store contents stay undefined.
// req_stall stays high until every result of the current request has been taken.

`include "floyd_sample_without_replacement_assert.svh"

module floyd_sample_without_replacement #(
   parameter int MAX_SAMPLES = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [fswr_pkg::DRAW_W-1:0]   req_draw,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [fswr_pkg::SLOT_W-1:0]   rsp_slot,
   output logic [fswr_pkg::DRAW_W-1:0]   rsp_picked_value,
   output logic                          rsp_last_of_run,
   output logic                          rsp_sample_done,
   output logic                          rsp_draw_error,

   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [fswr_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [fswr_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [fswr_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);

   localparam int DW    = fswr_pkg::DRAW_W;
   localparam int IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int KW    = (CNT_W > fswr_pkg::COUNT_W) ? CNT_W : fswr_pkg::COUNT_W;
   localparam int CMP_W = (VALUE_WIDTH > DW) ? VALUE_WIDTH : DW;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SUM,
      S_SUB,
      S_RANGE,
      S_SEARCH,
      S_WR1,
      S_OUT1,
      S_WR2
   } state_type;

   state_type state_ff;

   logic [DW-1:0]                  population_ff;
   logic [fswr_pkg::COUNT_W-1:0]   sample_count_ff;
   logic                           order_mode_ff;

   logic [IDX_W-1:0]  step_ff;
   logic [IDX_W-1:0]  i_ff;
   logic [DW-1:0]     draw_ff;
   logic [DW:0]       sum_ff;
   logic [DW-1:0]     m_ff;
   logic              neg_ff;
   logic              done_ff;
   logic              found_ff;
   logic [IDX_W-1:0]  j_ff;
   logic              second_ff;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic [IDX_W-1:0]  cmp_idx_ff;
   logic              cmp_vld_ff;

   logic                          rsp_valid_ff;
   logic [fswr_pkg::SLOT_W-1:0]   rsp_slot_ff;
   logic [DW-1:0]                 rsp_value_ff;
   logic                          rsp_last_ff;
   logic                          rsp_done_ff;
   logic                          rsp_err_ff;

   logic [KW-1:0]          k_eff;
   logic [DW+1:0]          diff;
   logic                   hit;
   logic [IDX_W-1:0]       i_last;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [VALUE_WIDTH-1:0] wr_data;
   logic [VALUE_WIDTH-1:0] first_val;
   logic [VALUE_WIDTH-1:0] rd_data;
   logic                   csr_wr;

   always_comb begin
      if (sample_count_ff == '0) begin
         k_eff = KW'(1);
      end else if (KW'(sample_count_ff) > KW'(MAX_SAMPLES)) begin
         k_eff = KW'(MAX_SAMPLES);
      end else begin
         k_eff = KW'(sample_count_ff);
      end
   end

   assign diff      = (DW+2)'(sum_ff) - (DW+2)'(k_eff);
   assign hit       = cmp_vld_ff && (CMP_W'(rd_data) == CMP_W'(draw_ff));
   assign i_last    = i_ff - IDX_W'(1);
   assign first_val = (!order_mode_ff && found_ff) ? VALUE_WIDTH'(m_ff)
                                                   : VALUE_WIDTH'(draw_ff);
   assign wr_en     = (state_ff == S_WR1) || (state_ff == S_WR2);
   assign wr_addr   = (state_ff == S_WR1) ? i_ff : j_ff;
   assign wr_data   = (state_ff == S_WR1) ? first_val : VALUE_WIDTH'(m_ff);
   assign csr_wr    = csr_psel && csr_penable && csr_pwrite && csr_pready;

   fswr_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (MAX_SAMPLES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         population_ff   <= fswr_pkg::POP_RESET;
         sample_count_ff <= fswr_pkg::COUNT_RESET;
         order_mode_ff   <= 1'b0;
         step_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
         cmp_vld_ff      <= 1'b0;
      end else begin
         if (csr_wr) begin
            case (csr_paddr[3:2])
               fswr_pkg::REG_POPULATION: population_ff   <= csr_pwdata[DW-1:0];
               fswr_pkg::REG_SAMPLE_CNT: sample_count_ff <= csr_pwdata[fswr_pkg::COUNT_W-1:0];
               fswr_pkg::REG_ORDER_MODE: order_mode_ff   <= csr_pwdata[0];
               default: ;
            endcase
         end

         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  draw_ff  <= req_draw;
                  i_ff     <= (KW'(step_ff) >= k_eff) ? '0 : step_ff;
                  step_ff  <= (KW'(step_ff) >= k_eff) ? '0 : step_ff;
                  state_ff <= S_SUM;
               end
            end
            S_SUM: begin
               sum_ff   <= (DW+1)'(population_ff) + (DW+1)'(i_ff);
               done_ff  <= (KW'(i_ff) + KW'(1)) >= k_eff;
               state_ff <= S_SUB;
            end
            S_SUB: begin
               neg_ff   <= diff[DW+1];
               m_ff     <= diff[DW-1:0];
               state_ff <= S_RANGE;
            end
            S_RANGE: begin
               found_ff   <= 1'b0;
               rd_idx_ff  <= '0;
               cmp_vld_ff <= 1'b0;
               if (neg_ff || (draw_ff > m_ff)) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_slot_ff  <= '0;
                  rsp_value_ff <= '0;
                  rsp_last_ff  <= 1'b1;
                  rsp_done_ff  <= 1'b0;
                  rsp_err_ff   <= 1'b1;
                  second_ff    <= 1'b0;
                  state_ff     <= S_OUT1;
               end else if (i_ff == '0) begin
                  state_ff <= S_WR1;
               end else begin
                  state_ff <= S_SEARCH;
               end
            end
            S_SEARCH: begin
               if (hit) begin
                  found_ff   <= 1'b1;
                  j_ff       <= cmp_idx_ff;
                  cmp_vld_ff <= 1'b0;
                  state_ff   <= S_WR1;
               end else if (cmp_vld_ff && (cmp_idx_ff == i_last)) begin
                  cmp_vld_ff <= 1'b0;
                  state_ff   <= S_WR1;
               end else begin
                  cmp_vld_ff <= (rd_idx_ff != i_ff);
                  cmp_idx_ff <= rd_idx_ff;
                  if (rd_idx_ff != i_ff) begin
                     rd_idx_ff <= rd_idx_ff + IDX_W'(1);
                  end
               end
            end
            S_WR1: begin
               rsp_valid_ff <= 1'b1;
               rsp_slot_ff  <= fswr_pkg::SLOT_W'(i_ff);
               rsp_value_ff <= DW'(CMP_W'(first_val));
               rsp_last_ff  <= !(order_mode_ff && found_ff);
               rsp_done_ff  <= done_ff;
               rsp_err_ff   <= 1'b0;
               second_ff    <= order_mode_ff && found_ff;
               step_ff      <= done_ff ? '0 : i_ff + IDX_W'(1);
               state_ff     <= S_OUT1;
            end
            S_OUT1: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  second_ff    <= 1'b0;
                  state_ff     <= second_ff ? S_WR2 : S_IDLE;
               end
            end
            S_WR2: begin
               rsp_valid_ff <= 1'b1;
               rsp_slot_ff  <= fswr_pkg::SLOT_W'(j_ff);
               rsp_value_ff <= DW'(CMP_W'(VALUE_WIDTH'(m_ff)));
               rsp_last_ff  <= 1'b1;
               rsp_err_ff   <= 1'b0;
               state_ff     <= S_OUT1;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         fswr_pkg::REG_POPULATION: csr_prdata = population_ff;
         fswr_pkg::REG_SAMPLE_CNT: csr_prdata = fswr_pkg::CSR_DW'(sample_count_ff);
         fswr_pkg::REG_ORDER_MODE: csr_prdata = fswr_pkg::CSR_DW'(order_mode_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   assign csr_pready       = 1'b1;
   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_picked_value = rsp_value_ff;
   assign rsp_last_of_run  = rsp_last_ff;
   assign rsp_sample_done  = rsp_done_ff;
   assign rsp_draw_error   = rsp_err_ff;

   `FSWR_ASSERT_NOW(a_idle_no_rsp, clock, reset, !req_stall, !rsp_valid, "rsp pending while idle")
   `FSWR_ASSERT_NOW(a_err_shape, clock, reset, rsp_valid && rsp_draw_error, rsp_last_of_run && !rsp_sample_done, "bad error result")
   `FSWR_ASSERT_NOW(a_cmp_range, clock, reset, cmp_vld_ff, cmp_idx_ff < i_ff, "search past step index")
   `FSWR_ASSERT_NEXT(a_second_follows, clock, reset, rsp_valid && !rsp_stall && !rsp_last_of_run, !rsp_valid && req_stall, "second write lost")

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int          MAX_PICKS    = 64;
   localparam int unsigned CYCLE_LIMIT  = 500000;
   localparam int          DRAIN_CYCLES = 80;

   typedef struct packed {
      logic [fswr_pkg::SLOT_W-1:0] slot;
      logic [fswr_pkg::DRAW_W-1:0] value;
      logic                        last_of_run;
      logic                        sample_done;
      logic                        rejected;
   } sample_write_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [fswr_pkg::DRAW_W-1:0] req_draw = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [fswr_pkg::SLOT_W-1:0] rsp_slot;
   logic [fswr_pkg::DRAW_W-1:0] rsp_picked_value;
   logic                        rsp_last_of_run;
   logic                        rsp_sample_done;
   logic                        rsp_draw_error;
   logic                        csr_psel = 1'b0;
   logic                        csr_penable = 1'b0;
   logic                        csr_pwrite = 1'b0;
   logic [fswr_pkg::CSR_AW-1:0] csr_paddr = '0;
   logic [fswr_pkg::CSR_DW-1:0] csr_pwdata = '0;
   logic [fswr_pkg::CSR_DW-1:0] csr_prdata;
   logic                        csr_pready;

   // model of the sample store and registers
   logic [fswr_pkg::DRAW_W-1:0]  picks [MAX_PICKS];
   logic [fswr_pkg::COUNT_W-1:0] next_slot  = '0;
   logic [fswr_pkg::DRAW_W-1:0]  population = fswr_pkg::POP_RESET;
   logic [fswr_pkg::COUNT_W-1:0] pick_count = fswr_pkg::COUNT_RESET;
   logic                         ordered    = 1'b0;

   sample_write_type pending_writes[$];

   int gap_pct  = 23;
   int hold_pct = 82;
   int failures = 0;
   int draws_sent = 0;
   int draws_rejected = 0;
   int repeats = 0;
   int samples_completed = 0;
   int writes_checked = 0;
   int csr_writes = 0;

   floyd_sample_without_replacement i_dut (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < hold_pct);
   end

   always @(posedge clock) begin : check_writes
      sample_write_type seen;
      sample_write_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = {rsp_slot, rsp_picked_value, rsp_last_of_run, rsp_sample_done, rsp_draw_error};
         if (pending_writes.size() == 0) begin
            $display("%0t: unexpected write, expected none, actual slot %0d value %h last %b done %b err %b",
                     $time, seen.slot, seen.value, seen.last_of_run, seen.sample_done,
                     seen.rejected);
            failures++;
         end else begin
            want = pending_writes.pop_front();
            writes_checked++;
            if (seen !== want) begin
               $display("%0t: write mismatch, expected slot %0d value %h last %b done %b err %b",
                        $time, want.slot, want.value, want.last_of_run, want.sample_done,
                        want.rejected);
               $display("%0t:                 actual slot %0d value %h last %b done %b err %b",
                        $time, seen.slot, seen.value, seen.last_of_run, seen.sample_done,
                        seen.rejected);
               failures++;
            end
         end
      end
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAIL floyd_sample_without_replacement");
      $finish;
   end

   function automatic int unsigned picks_needed();
      if (pick_count == 0) return 1;
      if (pick_count > MAX_PICKS) return MAX_PICKS;
      return pick_count;
   endfunction

   function automatic void queue_write(input int unsigned slot,
                                       input logic [fswr_pkg::DRAW_W-1:0] value,
                                       input logic last, input logic done, input logic rejected);
      sample_write_type w;
      w.slot        = fswr_pkg::SLOT_W'(slot);
      w.value       = value;
      w.last_of_run = last;
      w.sample_done = done;
      w.rejected    = rejected;
      pending_writes.push_back(w);
   endfunction

   function automatic void place_draw(input logic [fswr_pkg::DRAW_W-1:0] draw);
      int unsigned     kk;
      int unsigned     ii;
      int unsigned     hit;
      longint unsigned top;
      longint unsigned m;
      logic            found;
      logic            done;
      kk = picks_needed();
      if (next_slot >= kk) next_slot = '0;
      ii = next_slot;
      top = population;
      top += ii;
      if (top < kk || draw > top - kk) begin
         queue_write(0, '0, 1'b1, 1'b0, 1'b1);
         draws_rejected++;
         return;
      end
      m = top - kk;
      found = 1'b0;
      hit = 0;
      for (int unsigned j = 0; j < ii; j++) begin
         if (picks[j] == draw) begin
            found = 1'b1;
            hit = j;
            break;
         end
      end
      done = (ii + 1 >= kk);
      next_slot = done ? '0 : fswr_pkg::COUNT_W'(ii + 1);
      if (found) repeats++;
      if (done) samples_completed++;
      if (!ordered) begin
         picks[ii] = found ? fswr_pkg::DRAW_W'(m) : draw;
         queue_write(ii, picks[ii], 1'b1, done, 1'b0);
      end else begin
         picks[ii] = draw;
         if (!found) begin
            queue_write(ii, draw, 1'b1, done, 1'b0);
         end else begin
            picks[hit] = fswr_pkg::DRAW_W'(m);
            queue_write(ii, draw, 1'b0, done, 1'b0);
            queue_write(hit, fswr_pkg::DRAW_W'(m), 1'b1, done, 1'b0);
         end
      end
   endfunction

   // mostly legal draws, many repeating an earlier pick, some out of range
   function automatic logic [fswr_pkg::DRAW_W-1:0] pick_draw();
      int unsigned                 kk;
      int unsigned                 ii;
      int unsigned                 sel;
      longint unsigned             top;
      logic [fswr_pkg::DRAW_W-1:0] m;
      kk = picks_needed();
      ii = (next_slot >= kk) ? 0 : next_slot;
      top = population;
      top += ii;
      sel = $urandom_range(99);
      if (top < kk || sel < 8) return $urandom();
      m = fswr_pkg::DRAW_W'(top - kk);
      if (sel < 12) return m + 1;
      if (sel < 16) return $urandom_range(32'hFFFF_FFFF, m + 1);
      if (sel < 42 && ii > 0) return picks[$urandom_range(ii - 1, 0)];
      if (sel < 52) return m;
      if (sel < 64) return $urandom_range((m < 15) ? m : 15, 0);
      return $urandom_range(m, 0);
   endfunction

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_writes.size() != 0);
   endtask

   task automatic send_draw(input logic [fswr_pkg::DRAW_W-1:0] draw);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_draw  <= draw;
      do @(posedge clock); while (req_stall);
      place_draw(draw);
      draws_sent++;
   endtask

   task automatic csr_access(input logic write, input fswr_pkg::csr_index_type idx,
                             input logic [fswr_pkg::CSR_DW-1:0] wdata,
                             output logic [fswr_pkg::CSR_DW-1:0] rdata);
      settle();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= fswr_pkg::CSR_AW'({idx, 2'b00});
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (write) begin
         csr_writes++;
         case (idx)
            fswr_pkg::REG_POPULATION: population = wdata;
            fswr_pkg::REG_SAMPLE_CNT: pick_count = wdata[fswr_pkg::COUNT_W-1:0];
            fswr_pkg::REG_ORDER_MODE: ordered = wdata[0];
            default: ;
         endcase
      end
   endtask

   task automatic csr_write(input fswr_pkg::csr_index_type idx,
                            input logic [fswr_pkg::CSR_DW-1:0] value);
      logic [fswr_pkg::CSR_DW-1:0] unused;
      csr_access(1'b1, idx, value, unused);
   endtask

   task automatic check_register(input fswr_pkg::csr_index_type idx);
      logic [fswr_pkg::CSR_DW-1:0] got;
      logic [fswr_pkg::CSR_DW-1:0] want;
      case (idx)
         fswr_pkg::REG_POPULATION: want = population;
         fswr_pkg::REG_SAMPLE_CNT: want = fswr_pkg::CSR_DW'(pick_count);
         default: want = fswr_pkg::CSR_DW'(ordered);
      endcase
      csr_access(1'b0, idx, '0, got);
      if (got !== want) begin
         $display("%0t: register %0d read, expected %h actual %h", $time, idx, want, got);
         failures++;
      end
   endtask

   task automatic check_registers();
      check_register(fswr_pkg::REG_POPULATION);
      check_register(fswr_pkg::REG_SAMPLE_CNT);
      check_register(fswr_pkg::REG_ORDER_MODE);
   endtask

   task automatic test_register_access();
      check_registers();
   endtask

   task automatic test_plain_placement();
      send_draw(32'd0);
      send_draw(32'd63);
      csr_write(fswr_pkg::REG_POPULATION, 32'd10);
      csr_write(fswr_pkg::REG_SAMPLE_CNT, 32'd4);
      send_draw(32'd6);
      send_draw(32'd6);
      send_draw(32'd3);
      send_draw(32'd7);
   endtask

   task automatic test_ordered_placement();
      csr_write(fswr_pkg::REG_ORDER_MODE, 32'd1);
      send_draw(32'd2);
      send_draw(32'd2);
      send_draw(32'd7);
      send_draw(32'd9);
   endtask

   task automatic test_rejected_draws();
      csr_write(fswr_pkg::REG_ORDER_MODE, 32'd0);
      csr_write(fswr_pkg::REG_POPULATION, 32'hFFFF_FFFF);
      csr_write(fswr_pkg::REG_SAMPLE_CNT, 32'd64);
      send_draw(32'hFFFF_FFFF);
      send_draw(32'hFFFF_FFC0);
      send_draw(32'hFFFF_FFBF);
      send_draw(32'd0);
      // population too small for the remaining picks
      csr_write(fswr_pkg::REG_POPULATION, 32'd2);
      csr_write(fswr_pkg::REG_SAMPLE_CNT, 32'd5);
      send_draw(32'd1);
      csr_write(fswr_pkg::REG_POPULATION, 32'd0);
      send_draw(32'd0);
   endtask

   task automatic test_count_limits();
      csr_write(fswr_pkg::REG_SAMPLE_CNT, 32'd0);
      csr_write(fswr_pkg::REG_POPULATION, 32'd5);
      send_draw(32'd4);
      send_draw(32'd5);
      csr_write(fswr_pkg::REG_SAMPLE_CNT, 32'd100);
      csr_write(fswr_pkg::REG_POPULATION, 32'd70);
      send_draw(32'd6);
      send_draw(32'd6);
   endtask

   task automatic test_midsample_change();
      csr_write(fswr_pkg::REG_POPULATION, 32'd20);
      csr_write(fswr_pkg::REG_SAMPLE_CNT, 32'd8);
      csr_write(fswr_pkg::REG_ORDER_MODE, 32'd1);
      send_draw(32'd3);
      send_draw(32'd3);
      send_draw(32'd13);
      // step index beyond the new count restarts the sample
      csr_write(fswr_pkg::REG_SAMPLE_CNT, 32'd2);
      send_draw(32'd1);
      csr_write(fswr_pkg::REG_SAMPLE_CNT, 32'd8);
      send_draw(32'd1);
   endtask

   task automatic shuffle_settings();
      int unsigned                 sel;
      int unsigned                 kk;
      logic [fswr_pkg::CSR_DW-1:0] pop;
      if ($urandom_range(99) < 60) csr_write(fswr_pkg::REG_ORDER_MODE, $urandom_range(1, 0));
      if ($urandom_range(99) < 60) begin
         sel = $urandom_range(99);
         if (sel < 50) csr_write(fswr_pkg::REG_SAMPLE_CNT, $urandom_range(8, 1));
         else if (sel < 80) csr_write(fswr_pkg::REG_SAMPLE_CNT, $urandom_range(63, 9));
         else if (sel < 88) csr_write(fswr_pkg::REG_SAMPLE_CNT, 32'd64);
         else if (sel < 94) csr_write(fswr_pkg::REG_SAMPLE_CNT, 32'd0);
         else csr_write(fswr_pkg::REG_SAMPLE_CNT, $urandom_range(127, 65));
      end
      if ($urandom_range(99) < 70) begin
         kk = picks_needed();
         sel = $urandom_range(99);
         if (sel < 5) pop = $urandom_range(kk - 1, 0);
         else if (sel < 45) pop = kk + $urandom_range(8, 0);
         else if (sel < 70) pop = $urandom_range(1000, kk);
         else if (sel < 90) pop = $urandom_range(32'hFFFF_FFFF, kk);
         else pop = 32'hFFFF_FFFF;
         csr_write(fswr_pkg::REG_POPULATION, pop);
      end
      check_registers();
   endtask

   task automatic test_random_draws(input int count, input int sender_pct, input int receiver_pct);
      int left;
      gap_pct  = sender_pct;
      hold_pct = receiver_pct;
      left = 0;
      repeat (count) begin
         if (left == 0) begin
            shuffle_settings();
            left = $urandom_range(50, 10);
         end else if ($urandom_range(99) < 2) begin
            settle();
         end
         left--;
         send_draw(pick_draw());
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_register_access();
      test_plain_placement();
      test_ordered_placement();
      test_rejected_draws();
      test_count_limits();
      test_midsample_change();
      test_random_draws(195, 23, 82);
      test_random_draws(195, 82, 23);
      test_random_draws(195, 0, 0);
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d draws sent, %0d out of range, %0d hit an earlier pick, %0d samples completed",
               draws_sent, draws_rejected, repeats, samples_completed);
      $display("%0d writes checked over %0d register writes in plain and ordered modes",
               writes_checked, csr_writes);
      if (failures == 0 && pending_writes.size() == 0) begin
         $display("PASS floyd_sample_without_replacement");
      end else begin
         $display("FAIL floyd_sample_without_replacement");
      end
      $finish;
   end

endmodule
